>>> src/mort_pkg.sv
// ----------------------------------------------------------------------------
// mort_pkg: shared types and constants for the object range table
// Widths, request and status codes, table entry and result layouts.
// ----------------------------------------------------------------------------
`default_nettype none

package mort_pkg;

  localparam int LIVE_ENTRIES = 64;
  localparam int PHYS_PAGES   = 4096;
  localparam int PAGE_BITS    = 12;

  localparam int ENT_AW   = $clog2(LIVE_ENTRIES);
  localparam int PHYS_AW  = $clog2(PHYS_PAGES);
  localparam int ADDR_W   = 48;
  localparam int SIZE_W   = 48;
  localparam int CALLER_W = 64;
  localparam int ID_W     = 32;
  localparam int VPAGE_W  = 36;
  localparam int PPAGE_W  = 12;
  localparam int COUNT_W  = 13;
  localparam int TYPE_W   = 3;
  localparam int STAT_W   = 2;
  // middle first page is ceil(start / page): one bit above the page number
  localparam int MIDF_W   = ADDR_W - PAGE_BITS + 1;
  localparam int MIDC_W   = MIDF_W + 1;

  localparam logic [TYPE_W-1:0] REQ_ALLOC     = 3'd0;
  localparam logic [TYPE_W-1:0] REQ_FREE      = 3'd1;
  localparam logic [TYPE_W-1:0] REQ_MAP       = 3'd2;
  localparam logic [TYPE_W-1:0] REQ_MAP_RANGE = 3'd3;
  localparam logic [TYPE_W-1:0] REQ_VA_QUERY  = 3'd4;
  localparam logic [TYPE_W-1:0] REQ_PA_QUERY  = 3'd5;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd2;
  localparam logic [STAT_W-1:0] STAT_RANGE     = 2'd3;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SCAN, S_TAIL, S_PICK, S_FILL, S_PA_RD, S_PA_WAIT, S_DONE
  } state_t;

  typedef struct packed {
    logic [ADDR_W-1:0]        start;
    logic [ADDR_W-1:0]        end_addr;
    logic [CALLER_W-1:0]      caller;
    logic [ID_W-1:0]          id;
    logic                     is_large;
    logic [MIDF_W-1:0]        mid_first;
    logic signed [MIDC_W-1:0] mid_count;
  } entry_t;

  typedef struct packed {
    logic [ID_W-1:0]     object_id;
    logic [CALLER_W-1:0] object_caller;
    logic [ADDR_W-1:0]   object_start;
    logic [ADDR_W-1:0]   object_end;
    logic                in_large_middle;
    logic [STAT_W-1:0]   status;
  } result_t;

  typedef struct packed {
    logic               en;
    logic [PHYS_AW-1:0] addr;
    logic [ID_W-1:0]    data;
  } phys_wr_t;

endpackage

`default_nettype wire

>>> src/mort_if.sv
// ----------------------------------------------------------------------------
// mort_if: request and response channels
// Valid/ready channels carrying one request beat and one result beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface mort_req_if import mort_pkg::*;;
  logic                valid;
  logic                ready;
  logic [TYPE_W-1:0]   req_type;
  logic [ADDR_W-1:0]   vaddr;
  logic [SIZE_W-1:0]   size_bytes;
  logic [CALLER_W-1:0] caller_addr;
  logic [VPAGE_W-1:0]  virt_page;
  logic [PPAGE_W-1:0]  phys_page;
  logic [COUNT_W-1:0]  page_count;
  logic [ID_W-1:0]     given_id;

  modport source (output valid, req_type, vaddr, size_bytes, caller_addr, virt_page,
                  phys_page, page_count, given_id, input ready);
  modport sink (input valid, req_type, vaddr, size_bytes, caller_addr, virt_page,
                phys_page, page_count, given_id, output ready);
endinterface

interface mort_rsp_if import mort_pkg::*;;
  logic                valid;
  logic                ready;
  logic [ID_W-1:0]     object_id;
  logic [CALLER_W-1:0] object_caller;
  logic [ADDR_W-1:0]   object_start;
  logic [ADDR_W-1:0]   object_end;
  logic                in_large_middle;
  logic [STAT_W-1:0]   status;

  modport source (output valid, object_id, object_caller, object_start, object_end,
                  in_large_middle, status, input ready);
  modport sink (input valid, object_id, object_caller, object_start, object_end,
                in_large_middle, status, output ready);
endinterface

`default_nettype wire

>>> src/mort_phys_mem.sv
// ----------------------------------------------------------------------------
// mort_phys_mem: physical page owner table
// One write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module mort_phys_mem import mort_pkg::*; (
  input  wire logic               clk,
  input  wire phys_wr_t           wr,
  input  wire logic [PHYS_AW-1:0] rd_addr,
  output logic      [ID_W-1:0]    rd_data
);

  logic [ID_W-1:0] mem [PHYS_PAGES];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

>>> src/memory_object_range_table.sv
// ----------------------------------------------------------------------------
// memory_object_range_table: live allocation ranges and page owner table
// Tracks allocations by start address, maps physical pages to allocation ids
// and answers virtual and physical address queries.
// ----------------------------------------------------------------------------
// Channel   Dir  Beat
// req       in   one request (alloc, free, map, map range, va / pa query)
// rsp       out  one result per request
// cfg_we    in   write strobe for large_threshold (cfg_data)
//
// Alloc, free, map and va query sweep the 64-entry range memory, one read a
// cycle, then the tail and pick states. Map range writes page_count owners
// in turn, pa query reads the owner table, rejected or unknown requests go
// straight to the result; each returns to idle before the next accept.
// After reset a clearing pass writes zero to all 4096 page owners, one per
// cycle; no request is taken until it ends. Config writes are taken always.
// The result register frees the request side: a beat waits there while the
// next request is accepted; only its load waits on rsp.ready.
// ----------------------------------------------------------------------------
`default_nettype none

module memory_object_range_table import mort_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  mort_req_if.sink               req,
  mort_rsp_if.source             rsp,
  input  wire logic              cfg_we,
  input  wire logic [ADDR_W-1:0] cfg_data
);

  state_t state, state_next;

  logic [ADDR_W-1:0]       large_threshold;
  logic [ID_W-1:0]         next_id;
  logic [LIVE_ENTRIES-1:0] valid;

  // range memory
  entry_t            ent_mem [LIVE_ENTRIES];
  entry_t            ent_rd;
  entry_t            ent_wr;
  logic              ent_we;
  logic [ENT_AW-1:0] scan_idx;
  logic              ev_vld;
  logic [ENT_AW-1:0] ev_idx;

  // captured request
  logic [TYPE_W-1:0]   r_type;
  logic [ADDR_W-1:0]   r_base;
  logic [ADDR_W-1:0]   r_abase;
  logic [ADDR_W-1:0]   r_end;
  logic [CALLER_W-1:0] r_caller;
  logic                r_large;
  logic [ID_W-1:0]     r_id;
  logic [PPAGE_W-1:0]  r_ppage;
  logic [ID_W-1:0]     r_gid;
  logic [PHYS_AW-1:0]  fill_addr;
  logic [COUNT_W-1:0]  fill_left;
  logic [PHYS_AW-1:0]  clr_idx;

  // sweep results
  logic              p_ok, s_ok, a_ok, dup_ok, slot_ok;
  entry_t            p_ent, s_ent;
  logic              a_large;
  logic [MIDF_W-1:0] a_first;
  logic signed [MIDC_W-1:0] a_cnt;
  logic [ENT_AW-1:0] slot_idx;
  // start of the aligned-base predecessor, kept for its comparison
  logic [ADDR_W-1:0] a_first_start;

  result_t res, out_res, res_acc;
  logic    out_vld, out_load;

  phys_wr_t           phys_wr;
  logic [PHYS_AW-1:0] phys_rd_addr;
  logic [ID_W-1:0]    phys_rd;

  // accept-time decode
  logic              acc;
  logic [ADDR_W:0]   alloc_sum;
  logic              ppage_bad;
  logic              range_bad;
  assign acc       = req.valid && req.ready;
  assign alloc_sum = {1'b0, req.vaddr} + {1'b0, req.size_bytes};
  assign ppage_bad = {1'b0, req.phys_page} >= (PPAGE_W+1)'(PHYS_PAGES);
  assign range_bad = ({2'b0, req.phys_page} + {1'b0, req.page_count})
                     > (PPAGE_W+2)'(PHYS_PAGES);

  // result as known at accept: alloc id, early range errors
  always_comb begin
    res_acc = '0;
    if (req.req_type == REQ_ALLOC) begin
      res_acc.object_id = next_id;
      if (alloc_sum[ADDR_W]) res_acc.status = STAT_RANGE;
    end
    if ((req.req_type == REQ_MAP_RANGE && range_bad) ||
        (req.req_type == REQ_PA_QUERY && ppage_bad)) begin
      res_acc.status = STAT_RANGE;
    end
  end

  // window match for map / va query
  logic [ADDR_W:0] win_top;
  logic            p_hit, s_hit, found, map_wr;
  entry_t          f_ent;
  assign win_top = {1'b0, r_base} + (ADDR_W+1)'(1 << PAGE_BITS);
  assign p_hit   = p_ok && (r_base < p_ent.end_addr) && (win_top > {1'b0, p_ent.start});
  assign s_hit   = s_ok && (r_base < s_ent.end_addr) && (win_top > {1'b0, s_ent.start});
  assign found   = p_hit || s_hit;
  assign f_ent   = p_hit ? p_ent : s_ent;
  assign map_wr  = ({1'b0, r_ppage} < (PPAGE_W+1)'(PHYS_PAGES)) && found && (f_ent.id != '0);

  // large middle test on the query page
  logic [MIDC_W-1:0]        vp_ext;
  logic signed [MIDC_W-1:0] mid_top;
  logic                     mid_hit;
  assign vp_ext  = MIDC_W'(r_base >> PAGE_BITS);
  assign mid_top = $signed({1'b0, a_first}) + a_cnt;
  assign mid_hit = a_ok && a_large && (a_cnt > 0) && (vp_ext >= {1'b0, a_first})
                   && ($signed(vp_ext) < mid_top);

  // new entry for alloc
  logic [ADDR_W:0] ceil_sum;
  assign ceil_sum = {1'b0, r_base} + (ADDR_W+1)'((1 << PAGE_BITS) - 1);
  always_comb begin
    ent_wr          = '0;
    ent_wr.start    = r_base;
    ent_wr.end_addr = r_end;
    ent_wr.caller   = r_caller;
    ent_wr.id       = r_id;
    ent_wr.is_large = r_large;
    if (r_large) begin
      ent_wr.mid_first = MIDF_W'(ceil_sum >> PAGE_BITS);
      ent_wr.mid_count = $signed(MIDC_W'(r_end >> PAGE_BITS))
                         - $signed({1'b0, ent_wr.mid_first});
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (clr_idx == PHYS_AW'(PHYS_PAGES - 1)) state_next = S_IDLE;
      S_IDLE: begin
        if (acc) begin
          case (req.req_type)
            REQ_ALLOC:     state_next = alloc_sum[ADDR_W] ? S_DONE : S_SCAN;
            REQ_FREE:      state_next = S_SCAN;
            REQ_MAP:       state_next = S_SCAN;
            REQ_VA_QUERY:  state_next = S_SCAN;
            REQ_MAP_RANGE: state_next = range_bad ? S_DONE : S_FILL;
            REQ_PA_QUERY:  state_next = ppage_bad ? S_DONE : S_PA_RD;
            default:       state_next = S_DONE;
          endcase
        end
      end
      S_SCAN:    if (scan_idx == ENT_AW'(LIVE_ENTRIES - 1)) state_next = S_TAIL;
      S_TAIL:    state_next = S_PICK;
      S_PICK:    state_next = S_DONE;
      S_FILL:    if (fill_left == '0) state_next = S_DONE;
      S_PA_RD:   state_next = S_PA_WAIT;
      S_PA_WAIT: state_next = S_DONE;
      S_DONE:    if (!out_vld || rsp.ready) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // control strobes
  always_comb begin
    req.ready    = (state == S_IDLE);
    out_load     = (state == S_DONE) && (!out_vld || rsp.ready);
    ent_we       = (state == S_PICK) && (r_type == REQ_ALLOC) && !dup_ok && slot_ok;
    phys_rd_addr = PHYS_AW'(r_ppage);
    phys_wr      = '0;
    case (state)
      S_CLEAR: phys_wr = '{en: 1'b1, addr: clr_idx, data: '0};
      S_FILL:  phys_wr = '{en: (fill_left != '0), addr: fill_addr, data: r_gid};
      S_PICK:  phys_wr = '{en: (r_type == REQ_MAP) && map_wr, addr: PHYS_AW'(r_ppage),
                           data: f_ent.id};
      default: phys_wr = '0;
    endcase
  end

  // range memory
  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[slot_idx] <= ent_wr;
    end
    ent_rd <= ent_mem[scan_idx];
  end

  mort_phys_mem u_phys (
    .clk     (clk),
    .wr      (phys_wr),
    .rd_addr (phys_rd_addr),
    .rd_data (phys_rd)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_CLEAR;
      large_threshold <= ADDR_W'(2097152);
      next_id         <= ID_W'(1);
      valid           <= '0;
      clr_idx         <= '0;
      scan_idx        <= '0;
      ev_vld          <= 1'b0;
      out_vld         <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) large_threshold <= cfg_data;
      if (acc && req.req_type == REQ_ALLOC) next_id <= next_id + ID_W'(1);
      if (state == S_CLEAR) clr_idx <= clr_idx + PHYS_AW'(1);
      if (state == S_SCAN) scan_idx <= scan_idx + ENT_AW'(1);
      else scan_idx <= '0;
      ev_vld <= (state == S_SCAN);
      if (ev_vld && r_type == REQ_FREE && valid[ev_idx] && ent_rd.start == r_base) begin
        valid[ev_idx] <= 1'b0;
      end
      if (ent_we) valid[slot_idx] <= 1'b1;
      if (out_load) out_vld <= 1'b1;
      else if (rsp.ready) out_vld <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    ev_idx <= scan_idx;
    if (acc) begin
      r_type    <= req.req_type;
      r_base    <= (req.req_type == REQ_MAP)
                   ? ADDR_W'({req.virt_page, {PAGE_BITS{1'b0}}}) : req.vaddr;
      r_abase   <= (req.req_type == REQ_MAP)
                   ? ADDR_W'({req.virt_page, {PAGE_BITS{1'b0}}})
                   : {req.vaddr[ADDR_W-1:PAGE_BITS], {PAGE_BITS{1'b0}}};
      r_end     <= alloc_sum[ADDR_W-1:0];
      r_caller  <= req.caller_addr;
      r_large   <= req.size_bytes >= large_threshold;
      r_id      <= next_id;
      r_ppage   <= req.phys_page;
      r_gid     <= req.given_id;
      fill_addr <= PHYS_AW'(req.phys_page);
      fill_left <= req.page_count;
      p_ok      <= 1'b0;
      s_ok      <= 1'b0;
      a_ok      <= 1'b0;
      dup_ok    <= 1'b0;
      slot_ok   <= 1'b0;
      res       <= res_acc;
    end
    // one entry per cycle: exact start, free slot, pred, succ, aligned pred
    if (ev_vld) begin
      if (valid[ev_idx]) begin
        if (ent_rd.start == r_base) dup_ok <= 1'b1;
        if (ent_rd.start <= r_base && (!p_ok || ent_rd.start > p_ent.start)) begin
          p_ok  <= 1'b1;
          p_ent <= ent_rd;
        end
        if (ent_rd.start > r_base && (!s_ok || ent_rd.start < s_ent.start)) begin
          s_ok  <= 1'b1;
          s_ent <= ent_rd;
        end
        if (ent_rd.start <= r_abase && (!a_ok || ent_rd.start > a_first_start)) begin
          a_ok    <= 1'b1;
          a_large <= ent_rd.is_large;
          a_first <= ent_rd.mid_first;
          a_cnt   <= ent_rd.mid_count;
        end
      end else if (!slot_ok) begin
        slot_ok  <= 1'b1;
        slot_idx <= ev_idx;
      end
    end
    if (state == S_FILL && fill_left != '0) begin
      fill_addr <= fill_addr + PHYS_AW'(1);
      fill_left <= fill_left - COUNT_W'(1);
    end
    if (state == S_PICK) begin
      case (r_type)
        REQ_ALLOC: if (!dup_ok && !slot_ok) res.status <= STAT_FULL;
        REQ_FREE:  res.status <= dup_ok ? STAT_OK : STAT_NOT_FOUND;
        REQ_MAP, REQ_VA_QUERY: begin
          if (found) begin
            res.object_id     <= f_ent.id;
            res.object_caller <= f_ent.caller;
            res.object_start  <= f_ent.start;
            res.object_end    <= f_ent.end_addr;
          end
          if (r_type == REQ_VA_QUERY) begin
            res.in_large_middle <= mid_hit;
            res.status          <= found ? STAT_OK : STAT_NOT_FOUND;
          end else if ({1'b0, r_ppage} >= (PPAGE_W+1)'(PHYS_PAGES)) begin
            res.status <= STAT_RANGE;
          end else begin
            res.status <= found ? STAT_OK : STAT_NOT_FOUND;
          end
        end
        default: res.status <= res.status;
      endcase
    end
    if (state == S_PA_WAIT) begin
      res.object_id <= phys_rd;
      res.status    <= (phys_rd == '0) ? STAT_NOT_FOUND : STAT_OK;
    end
    if (out_load) out_res <= res;
  end

  always_ff @(posedge clk) begin
    if (ev_vld && valid[ev_idx] && ent_rd.start <= r_abase &&
        (!a_ok || ent_rd.start > a_first_start)) begin
      a_first_start <= ent_rd.start;
    end
  end

  assign rsp.valid           = out_vld;
  assign rsp.object_id       = out_res.object_id;
  assign rsp.object_caller   = out_res.object_caller;
  assign rsp.object_start    = out_res.object_start;
  assign rsp.object_end      = out_res.object_end;
  assign rsp.in_large_middle = out_res.in_large_middle;
  assign rsp.status          = out_res.status;

  // an alloc only ever fills a free slot
  a_alloc_free_slot: assert property (@(posedge clk) disable iff (rst)
    ent_we |-> !valid[slot_idx]) else $error("alloc overwrote a live entry");

  // every accepted alloc consumes one id
  a_id_step: assert property (@(posedge clk) disable iff (rst)
    (acc && req.req_type == REQ_ALLOC) |=> next_id == ID_W'($past(next_id) + ID_W'(1)))
    else $error("id counter did not advance");

  // map never records a zero owner
  a_map_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_PICK && phys_wr.en) |-> phys_wr.data != '0)
    else $error("map wrote a zero id");

  // sweep data only arrives while sweeping
  a_sweep_window: assert property (@(posedge clk) disable iff (rst)
    ev_vld |-> (state == S_SCAN || state == S_TAIL))
    else $error("range read outside sweep");

endmodule

`default_nettype wire

>>> sim/mort_tb_if.sv
// ----------------------------------------------------------------------------
// mort_tb_if: testbench view of the object range table channels
// Reuses the block's own request and result interfaces; adds the request_t row.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mort_tb_pkg;
  import mort_pkg::*;

  typedef struct {
    logic [TYPE_W-1:0]   req_type;
    logic [ADDR_W-1:0]   vaddr;
    logic [SIZE_W-1:0]   size_bytes;
    logic [CALLER_W-1:0] caller_addr;
    logic [VPAGE_W-1:0]  virt_page;
    logic [PPAGE_W-1:0]  phys_page;
    logic [COUNT_W-1:0]  page_count;
    logic [ID_W-1:0]     given_id;
  } request_t;
endpackage

>>> sim/memory_object_range_table_tb.sv
// ----------------------------------------------------------------------------
// memory_object_range_table_tb: self-checking bench for the object range table
// Directed rows then random alloc/free/map/query traffic; every result beat is
// compared with an in-bench model of the range and page owner tables.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module memory_object_range_table_tb;
  import mort_pkg::*;
  import mort_tb_pkg::*;

  localparam int N_RANDOM = 1700;
  localparam logic [ADDR_W-1:0] PAGE = 48'd1 << PAGE_BITS;
  localparam logic [ADDR_W-1:0] MAX48 = {ADDR_W{1'b1}};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [ADDR_W-1:0] cfg_data = '0;

  mort_req_if req ();
  mort_rsp_if rsp ();

  memory_object_range_table u_top (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // ---- shadow copy of the block's tables ----
  logic [ADDR_W-1:0]   thr;
  logic                ent_valid [LIVE_ENTRIES];
  logic [ADDR_W-1:0]   ent_start [LIVE_ENTRIES];
  logic [ADDR_W-1:0]   ent_end   [LIVE_ENTRIES];
  logic [CALLER_W-1:0] ent_caller[LIVE_ENTRIES];
  logic [ID_W-1:0]     ent_id    [LIVE_ENTRIES];
  logic                ent_large [LIVE_ENTRIES];
  longint              ent_midf  [LIVE_ENTRIES];
  longint              ent_midc  [LIVE_ENTRIES];
  logic [ID_W-1:0]     page_owner[PHYS_PAGES];
  logic [ID_W-1:0]     id_counter;

  result_t pending_results[$];
  int      n_bad = 0;
  bit      drained_once = 0;

  function automatic int nearest_below(logic [ADDR_W-1:0] a);
    int best;
    best = -1;
    for (int i = 0; i < LIVE_ENTRIES; i++)
      if (ent_valid[i] && ent_start[i] <= a &&
          (best < 0 || ent_start[i] > ent_start[best])) best = i;
    return best;
  endfunction

  function automatic int nearest_above(logic [ADDR_W-1:0] a);
    int best;
    best = -1;
    for (int i = 0; i < LIVE_ENTRIES; i++)
      if (ent_valid[i] && ent_start[i] > a &&
          (best < 0 || ent_start[i] < ent_start[best])) best = i;
    return best;
  endfunction

  // window test in 49 bits: the top of the last page is 2^48
  function automatic bit hits_window(int k, logic [ADDR_W-1:0] base);
    logic [ADDR_W:0] top;
    top = {1'b0, base} + {1'b0, PAGE};
    return base < ent_end[k] && top > {1'b0, ent_start[k]};
  endfunction

  function automatic int range_at(logic [ADDR_W-1:0] base);
    int p;
    p = nearest_below(base);
    if (p >= 0 && hits_window(p, base)) return p;
    p = nearest_above(base);
    if (p >= 0 && hits_window(p, base)) return p;
    return -1;
  endfunction

  function automatic result_t owner_step(request_t r);
    result_t o;
    logic [ADDR_W:0] end49;
    logic [ADDR_W-1:0] base;
    logic [VPAGE_W-1:0] vp;
    int k, dup, slot, p;
    o = '0;
    case (r.req_type)
      REQ_ALLOC: begin
        o.object_id = id_counter;
        id_counter++;
        end49 = {1'b0, r.vaddr} + {1'b0, r.size_bytes};
        if (end49[ADDR_W]) o.status = STAT_RANGE;
        else begin
          dup = -1; slot = -1;
          for (int i = 0; i < LIVE_ENTRIES; i++) begin
            if (ent_valid[i] && ent_start[i] == r.vaddr) dup = i;
            if (!ent_valid[i] && slot < 0) slot = i;
          end
          if (dup < 0) begin
            if (slot < 0) o.status = STAT_FULL;
            else begin
              ent_valid[slot] = 1'b1; ent_start[slot] = r.vaddr;
              ent_end[slot] = end49[ADDR_W-1:0]; ent_caller[slot] = r.caller_addr;
              ent_id[slot] = o.object_id;
              ent_large[slot] = r.size_bytes >= thr;
              ent_midf[slot] = (longint'(r.vaddr) + PAGE - 1) >>> PAGE_BITS;
              ent_midc[slot] = (longint'(end49) >>> PAGE_BITS) - ent_midf[slot];
            end
          end
        end
      end
      REQ_FREE: begin
        o.status = STAT_NOT_FOUND;
        for (int i = 0; i < LIVE_ENTRIES; i++)
          if (ent_valid[i] && ent_start[i] == r.vaddr) begin
            ent_valid[i] = 1'b0; o.status = STAT_OK;
          end
      end
      REQ_MAP, REQ_VA_QUERY: begin
        base = (r.req_type == REQ_MAP) ? ADDR_W'(r.virt_page) << PAGE_BITS : r.vaddr;
        k = range_at(base);
        if (k >= 0) begin
          o.object_id = ent_id[k]; o.object_caller = ent_caller[k];
          o.object_start = ent_start[k]; o.object_end = ent_end[k];
        end
        if (r.req_type == REQ_MAP) begin
          // phys_page is 12 bits, so it is always inside the page table
          if (k < 0) o.status = STAT_NOT_FOUND;
          else if (ent_id[k] != 0) page_owner[r.phys_page] = ent_id[k];
        end else begin
          if (k < 0) o.status = STAT_NOT_FOUND;
          vp = VPAGE_W'(r.vaddr >> PAGE_BITS);
          p = nearest_below(ADDR_W'(vp) << PAGE_BITS);
          if (p >= 0 && ent_large[p] && ent_midc[p] > 0 &&
              longint'(vp) >= ent_midf[p] && longint'(vp) < ent_midf[p] + ent_midc[p])
            o.in_large_middle = 1'b1;
        end
      end
      REQ_MAP_RANGE: begin
        if (int'(r.phys_page) + int'(r.page_count) > PHYS_PAGES) o.status = STAT_RANGE;
        else for (int i = 0; i < r.page_count; i++) page_owner[r.phys_page + i] = r.given_id;
      end
      REQ_PA_QUERY: begin
        o.object_id = page_owner[r.phys_page];
        if (o.object_id == 0) o.status = STAT_NOT_FOUND;
      end
      default: ;
    endcase
    return o;
  endfunction

  // ---- result side: random stalls, compare against oldest expectation ----
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 3) == 0) rsp.ready = ($urandom_range(0, 9) == 0) ? 1'b1 : 1'b0;
      else rsp.ready = ($urandom_range(0, 5) != 0);
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      result_t got, want;
      got = '{rsp.object_id, rsp.object_caller, rsp.object_start, rsp.object_end,
              rsp.in_large_middle, rsp.status};
      if (pending_results.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected beat %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          n_bad++;
          if (n_bad <= 10) $display("beat differs: want %p got %p", want, got);
        end
      end
    end
  end

  // ---- request side ----
  task automatic send(request_t r, bit check_typed = 0, result_t typed = '0);
    result_t pred;
    req.valid = 1'b1;
    req.req_type = r.req_type; req.vaddr = r.vaddr; req.size_bytes = r.size_bytes;
    req.caller_addr = r.caller_addr; req.virt_page = r.virt_page;
    req.phys_page = r.phys_page; req.page_count = r.page_count; req.given_id = r.given_id;
    do @(posedge clk); while (!req.ready);
    pred = owner_step(r);
    // typed rows are read straight off the spec; flag if the model disagrees too
    if (check_typed && pred !== typed) begin
      n_bad++;
      if (n_bad <= 10) $display("typed row differs: want %p model %p", typed, pred);
    end
    pending_results = {pending_results, pred};
    @(negedge clk);
    req.valid = 1'b0;
    if ($urandom_range(0, 2) == 0)
      repeat (($urandom_range(0, 15) == 0) ? $urandom_range(20, 150) : $urandom_range(1, 3))
        @(negedge clk);
  endtask

  task automatic wait_idle();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic set_threshold(logic [ADDR_W-1:0] v);
    wait_idle();
    cfg_we = 1'b1; cfg_data = v;
    @(negedge clk);
    cfg_we = 1'b0;
    thr = v;
  endtask

  function automatic request_t mk(logic [TYPE_W-1:0] t, logic [ADDR_W-1:0] va = 0,
      logic [SIZE_W-1:0] sz = 0, logic [CALLER_W-1:0] ca = 0, logic [VPAGE_W-1:0] vp = 0,
      logic [PPAGE_W-1:0] pp = 0, logic [COUNT_W-1:0] pc = 0, logic [ID_W-1:0] gi = 0);
    request_t r;
    r = '{t, va, sz, ca, vp, pp, pc, gi};
    return r;
  endfunction

  // addresses drawn from a small pool so frees, duplicates and hits are common
  function automatic logic [ADDR_W-1:0] pick_addr();
    case ($urandom_range(0, 5))
      0: return ADDR_W'({$urandom, $urandom});
      1: return MAX48 - ADDR_W'($urandom_range(0, 9000));
      default: return ADDR_W'(48'h10_0000 * ADDR_W'($urandom_range(0, 40))
                              + ADDR_W'($urandom_range(0, 3)) * 48'h800);
    endcase
  endfunction

  function automatic request_t random_request();
    request_t r;
    int sel;
    r = mk(REQ_ALLOC);
    r.caller_addr = {$urandom, $urandom};
    r.given_id = $urandom;
    r.virt_page = VPAGE_W'({$urandom, $urandom});
    r.phys_page = PPAGE_W'($urandom);
    r.page_count = COUNT_W'($urandom_range(0, 8));
    r.vaddr = pick_addr();
    r.size_bytes = ($urandom_range(0, 4) == 0) ? SIZE_W'({$urandom, $urandom})
                                               : SIZE_W'($urandom_range(0, 32'h30_0000));
    sel = $urandom_range(0, 99);
    if (sel < 28) r.req_type = REQ_ALLOC;
    else if (sel < 45) r.req_type = REQ_FREE;
    else if (sel < 60) begin
      r.req_type = REQ_MAP;
      if ($urandom_range(0, 3) != 0) r.virt_page = VPAGE_W'(pick_addr() >> PAGE_BITS);
    end else if (sel < 66) begin
      r.req_type = REQ_MAP_RANGE;
      if ($urandom_range(0, 9) == 0) r.page_count = COUNT_W'($urandom_range(0, 4096));
    end else if (sel < 86) r.req_type = REQ_VA_QUERY;
    else if (sel < 97) r.req_type = REQ_PA_QUERY;
    else r.req_type = TYPE_W'($urandom_range(6, 7));
    return r;
  endfunction

  typedef struct {
    request_t req_row;
    bit       typed;
    result_t  want;
  } stim_row_t;

  initial begin
    stim_row_t rows[$];
    req.valid = 1'b0;
    req.req_type = '0; req.vaddr = '0; req.size_bytes = '0; req.caller_addr = '0;
    req.virt_page = '0; req.phys_page = '0; req.page_count = '0; req.given_id = '0;
    thr = 48'd2097152;
    for (int i = 0; i < LIVE_ENTRIES; i++) ent_valid[i] = 1'b0;
    for (int i = 0; i < PHYS_PAGES; i++) page_owner[i] = '0;
    id_counter = 32'd1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed table
    rows = '{
      '{mk(REQ_PA_QUERY, 0, 0, 0, 0, 12'd0), 1, '{0, 0, 0, 0, 0, STAT_NOT_FOUND}},
      '{mk(REQ_PA_QUERY, 0, 0, 0, 0, 12'hFFF), 1, '{0, 0, 0, 0, 0, STAT_NOT_FOUND}},
      '{mk(REQ_VA_QUERY, MAX48), 1, '{0, 0, 0, 0, 0, STAT_NOT_FOUND}},
      '{mk(REQ_FREE, 48'h1000), 1, '{0, 0, 0, 0, 0, STAT_NOT_FOUND}},
      '{mk(REQ_ALLOC, MAX48, 48'd1), 1, '{1, 0, 0, 0, 0, STAT_RANGE}},
      '{mk(REQ_ALLOC, MAX48, 48'd0, 64'hFFFF_FFFF_FFFF_FFFF), 0, '0},
      '{mk(REQ_ALLOC, 48'h1800, 48'h40_0000, 64'h1234), 0, '0},
      '{mk(REQ_ALLOC, 48'h1800, 48'h10, 64'h5), 0, '0},
      '{mk(REQ_ALLOC, 48'h0, 48'h0), 0, '0},
      '{mk(REQ_VA_QUERY, 48'h2000), 0, '0},
      '{mk(REQ_VA_QUERY, 48'h1000), 0, '0},
      '{mk(REQ_VA_QUERY, 48'h40_1000), 0, '0},
      '{mk(REQ_VA_QUERY, MAX48 - 48'hFFF), 0, '0},
      '{mk(REQ_MAP, 0, 0, 0, 36'h2, 12'h0), 0, '0},
      '{mk(REQ_MAP, 0, 0, 0, 36'hF_FFFF_FFFF, 12'hFFF), 0, '0},
      '{mk(REQ_MAP_RANGE, 0, 0, 0, 0, 12'hFFF, 13'd2, 32'hFFFF_FFFF), 1,
        '{0, 0, 0, 0, 0, STAT_RANGE}},
      '{mk(REQ_MAP_RANGE, 0, 0, 0, 0, 12'd0, 13'd4096, 32'hFFFF_FFFF), 1, '0},
      '{mk(REQ_MAP_RANGE, 0, 0, 0, 0, 12'hFFF, 13'd0, 32'h1), 1, '0},
      '{mk(REQ_PA_QUERY, 0, 0, 0, 0, 12'hFFF), 1, '{32'hFFFF_FFFF, 0, 0, 0, 0, STAT_OK}},
      '{mk(REQ_MAP_RANGE, 0, 0, 0, 0, 12'd0, 13'd4096, 32'h0), 1, '0},
      '{mk(REQ_FREE, 48'h1800), 1, '0},
      '{mk(3'd6, MAX48, MAX48, 64'hFFFF_FFFF_FFFF_FFFF, 36'hF_FFFF_FFFF, 12'hFFF, 13'h1FFF,
        32'hFFFF_FFFF), 1, '0},
      '{mk(3'd7), 1, '0}
    };
    foreach (rows[i]) send(rows[i].req_row, rows[i].typed, rows[i].want);

    // random phases over threshold settings, extremes included
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_threshold(48'd1);
        1: set_threshold(MAX48);
        2: set_threshold(48'd2097152);
        default: set_threshold(48'h1_0000);
      endcase
      for (int n = 0; n < N_RANDOM / 4; n++) begin
        if (n == 200 && !drained_once) begin
          wait_idle();   // sender holds off until the result queue drains
          drained_once = 1;
        end
        send(random_request());
      end
    end

    wait_idle();
    if (n_bad == 0) $display("memory_object_range_table: match");
    else $display("memory_object_range_table: mismatch");
    $finish;
  end

  initial begin
    #40ms;
    $display("memory_object_range_table: mismatch");
    $finish;
  end

endmodule

>>> files.f
src/mort_pkg.sv
src/mort_if.sv
src/mort_phys_mem.sv
src/memory_object_range_table.sv
sim/mort_tb_if.sv
sim/memory_object_range_table_tb.sv
